FILE: rtl/core/mrf_pkg.sv
package mrf_pkg;

    // Frame constants
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  QTY_HIGH          = 8'h00;
    localparam logic [7:0]  QTY_LOW           = 8'h02;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Byte positions within one request frame, in transmit order
    typedef enum logic [2:0] {
        POS_STATION,
        POS_FUNC,
        POS_ADDR_A,
        POS_ADDR_B,
        POS_QTY_HI,
        POS_QTY_LO,
        POS_CRC_A,
        POS_CRC_B
    } byte_pos_t;

    // One classified request, address bytes already in transmit order
    typedef struct packed {
        logic [7:0] station;
        logic [7:0] addr_first;
        logic [7:0] addr_second;
        logic       swap;
    } req_entry_t;

    // Modbus CRC-16, one byte folded in (eight reflected shift steps)
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

endpackage

FILE: rtl/core/mrf_front.sv
module mrf_front
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  station_number,
    input  logic [15:0] register_address,
    input  logic        swap_order,
    output logic        push,
    output req_entry_t  push_entry,
    input  logic        q_full
);

    logic       valid_reg;
    logic       valid_next;
    req_entry_t entry_reg;
    req_entry_t entry_next;
    logic       take;

    // Hold an item until the queue has room
    assign push     = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    // Classify: put the address bytes in transmit order
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (take)
        begin
            entry_next.station = station_number;
            entry_next.swap    = swap_order;
            if (swap_order)
            begin
                entry_next.addr_first  = register_address[7:0];
                entry_next.addr_second = register_address[15:8];
            end
            else
            begin
                entry_next.addr_first  = register_address[15:8];
                entry_next.addr_second = register_address[7:0];
            end
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_entry = entry_reg;

endmodule

FILE: rtl/core/mrf_queue.sv
module mrf_queue
    import mrf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  req_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output req_entry_t head_entry
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    req_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign q_valid    = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // No overflow, no underflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");

endmodule

FILE: rtl/core/mrf_back.sv
module mrf_back
    import mrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  req_entry_t head_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       last_byte
);

    logic        busy_reg;
    logic        busy_next;
    byte_pos_t   idx_reg;
    byte_pos_t   idx_next;
    req_entry_t  cur_reg;
    req_entry_t  cur_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        last_reg;
    logic        last_next;
    logic        load;
    logic        done;
    logic [7:0]  byte_val;
    logic [15:0] crc_base;

    // Output register free or draining this cycle
    assign load = busy_reg && (!out_valid_reg || !out_stall);
    assign done = load && (idx_reg == POS_CRC_B);
    assign pop  = q_valid && (!busy_reg || done);

    // Byte for the current position
    always_comb
    begin
        unique case (idx_reg)
            POS_STATION: byte_val = cur_reg.station;
            POS_FUNC:    byte_val = FUNC_READ_HOLDING;
            POS_ADDR_A:  byte_val = cur_reg.addr_first;
            POS_ADDR_B:  byte_val = cur_reg.addr_second;
            POS_QTY_HI:  byte_val = QTY_HIGH;
            POS_QTY_LO:  byte_val = QTY_LOW;
            POS_CRC_A:   byte_val = cur_reg.swap ? crc_reg[15:8] : crc_reg[7:0];
            POS_CRC_B:   byte_val = cur_reg.swap ? crc_reg[7:0] : crc_reg[15:8];
            default:     byte_val = '0;
        endcase
    end

    // Running CRC over the first six bytes as they go out
    assign crc_base = (idx_reg == POS_STATION) ? CRC_INIT : crc_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        if (!out_stall)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            byte_next      = byte_val;
            last_next      = (idx_reg == POS_CRC_B);
            idx_next       = byte_pos_t'(idx_reg + 3'd1);
            if (idx_reg <= POS_QTY_LO)
                crc_next = crc16_byte(crc_base, byte_val);
            if (done)
                busy_next = 1'b0;
        end

        // Next frame starts right after the last byte of this one
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = POS_STATION;
            cur_next  = head_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= POS_STATION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

    // A frame is only taken up when idle or as the previous one finishes
    a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!busy_reg || idx_reg == POS_CRC_B))
        else $error("new frame started mid-frame");

    // The last flag follows a load from the final position
    a_last_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        (load && idx_reg == POS_CRC_B) |=> (out_valid_reg && last_reg))
        else $error("last byte not flagged");

endmodule

FILE: rtl/core/modbus_read_request_framer.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | station_number, register_address, swap_order
// output  | out       | out_valid/out_stall | frame_byte, last_byte
//
// Each item yields eight output bytes, one per cycle while the output does not stall;
// the byte serializer takes a new item as it loads the last byte of the previous one.
// The CRC is folded in one byte per cycle, while the output does not stall, as the first six bytes are sent.
// Input items are buffered in a front register plus a QUEUE_DEPTH-entry queue.
// Reset clears all valid flags and pointers; payload holds no reset value.
// Output stalls back up into the queue and then stall the input side.
module modbus_read_request_framer
    import mrf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  station_number,
    input  logic [15:0] register_address,
    input  logic        swap_order,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic       push;
    req_entry_t push_entry;
    logic       q_full;
    logic       pop;
    logic       q_valid;
    req_entry_t head_entry;

    mrf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .station_number   (station_number),
        .register_address (register_address),
        .swap_order       (swap_order),
        .push             (push),
        .push_entry       (push_entry),
        .q_full           (q_full)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head_entry (head_entry)
    );

    mrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule
